// ----- src/bral_pkg.sv -----
// shared constants, types and codes of the boot region table allocator
`default_nettype none
package bral_pkg;

   localparam int ADDR_BITS     = 48;
   localparam int PAGE_BYTES    = 4096;
   localparam int PAGE_BITS     = $clog2(PAGE_BYTES);
   localparam int REGION_SLOTS  = 64;
   localparam int SLOT_IDX_BITS = $clog2(REGION_SLOTS);
   localparam int SLOT_CNT_BITS = SLOT_IDX_BITS + 1;
   localparam int ALIGN_BITS    = 6;
   localparam int DEPTH_BITS    = 2;
   localparam int SPLIT_LIMIT   = 2;
   localparam int STACK_DEPTH   = 2;
   localparam int STACK_IDX_BITS = 1;
   localparam int STACK_CNT_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [ADDR_BITS-1:0] addr_type;

   localparam addr_type ADDR_MASK        = {ADDR_BITS{1'b1}};
   localparam addr_type PAGE_ADDR        = addr_type'(PAGE_BYTES);
   localparam addr_type KERNEL_START_RST = addr_type'(48'h10_0000);
   localparam addr_type KERNEL_END_RST   = addr_type'(48'h20_0000);
   localparam addr_type VGA_BASE_RST     = addr_type'(48'h0B_8000);

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_OOM  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KERNEL_START = 2'd0,
      CSR_KERNEL_END   = 2'd1,
      CSR_VGA_BASE     = 2'd2
   } csr_idx_type;

   typedef enum logic {
      MODE_ADD   = 1'b0,
      MODE_ALLOC = 1'b1
   } mode_type;

   typedef struct packed {
      logic load;
      logic norm;
      logic classify;
      logic scan;
      logic resp_load;
   } bral_cmd_type;

   typedef struct packed {
      logic add_done;
      logic scan_done;
   } bral_stat_type;

endpackage
`default_nettype wire

// ----- src/bral_ifs.sv -----
// request, response and register write channel interfaces
`default_nettype none
interface bral_req_if;
   import bral_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   addr_type              range_start;
   addr_type              range_end;
   addr_type              length;
   logic [ALIGN_BITS-1:0] align_log2;
   modport source (output valid, mode, range_start, range_end, length, align_log2,
                   input ready);
   modport sink   (input valid, mode, range_start, range_end, length, align_log2,
                   output ready);
endinterface

interface bral_rsp_if;
   import bral_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   addr_type   address;
   modport source (output valid, status, address, input ready);
   modport sink   (input valid, status, address, output ready);
endinterface

interface bral_csr_if;
   import bral_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   addr_type                  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/boot_region_table_allocator_unit.sv -----
// top level of the boot region table allocator
`default_nettype none
// Keeps a table of 64 physical memory regions. An add request (mode 0) rounds
// its range inward to pages, cuts out the kernel image and the display page,
// and stores the remaining pieces in order, examining at most seven pieces. An
// alloc request (mode 1) is a first-fit aligned bump allocation: the slot
// memory is read one slot per cycle through a three-stage pipeline, and the
// scan stops at the first slot that fits. One request is worked at a time; a
// finished response waits in the output register while the next request is
// taken. Registers may be written only while idle; the register channel is
// always ready. No clearing pass is needed after reset.
module boot_region_table_allocator_unit (
   input  wire logic clock,
   input  wire logic reset,
   bral_req_if.sink   req_bus,
   bral_rsp_if.source rsp_bus,
   bral_csr_if.sink   csr_bus
);
   import bral_pkg::*;

   bral_cmd_type  cmd;
   bral_stat_type stat;

   assign csr_bus.ready = 1'b1;

   bral_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bral_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_range_start (req_bus.range_start),
      .req_range_end   (req_bus.range_end),
      .req_length      (req_bus.length),
      .req_align_log2  (req_bus.align_log2),
      .csr_we          (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_status      (rsp_bus.status),
      .rsp_address     (rsp_bus.address)
   );

endmodule
`default_nettype wire

// ----- src/bral_dpath.sv -----
// datapath: region table memory, piece splitter and first-fit scan pipeline
`default_nettype none
module bral_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bral_pkg::bral_cmd_type        cmd,
   output bral_pkg::bral_stat_type            stat,
   input  wire bral_pkg::addr_type            req_range_start,
   input  wire bral_pkg::addr_type            req_range_end,
   input  wire bral_pkg::addr_type            req_length,
   input  wire logic [bral_pkg::ALIGN_BITS-1:0] req_align_log2,
   input  wire logic                          csr_we,
   input  wire logic [bral_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire bral_pkg::addr_type            csr_data,
   output logic [1:0]                         rsp_status,
   output bral_pkg::addr_type                 rsp_address
);
   import bral_pkg::*;

   localparam int HI_BITS = ADDR_BITS - PAGE_BITS;

   // configuration
   addr_type kernel_start_ff, kernel_end_ff, vga_base_ff, vga_end_ff, vga_end_in;
   logic [ADDR_BITS:0] vga_sum;

   // table storage
   addr_type slot_start_mem [REGION_SLOTS];
   addr_type slot_end_mem   [REGION_SLOTS];
   logic [SLOT_CNT_BITS-1:0] next_slot_ff, next_slot_in;

   // add path
   addr_type piece_s_ff, piece_e_ff;
   logic [DEPTH_BITS-1:0] piece_d_ff;
   addr_type ns_ff, ne_ff;
   logic nempty_ff;
   addr_type stk_s_ff [STACK_DEPTH];
   addr_type stk_e_ff [STACK_DEPTH];
   logic [DEPTH_BITS-1:0] stk_d_ff [STACK_DEPTH];
   logic [STACK_CNT_BITS-1:0] sp_ff, sp_in;
   logic full_ff, full_in;

   logic [HI_BITS-1:0] s_hi, s_hi_up;
   logic s_frac_nz, s_over;
   addr_type s_up, s_norm, e_norm;
   logic in_k, ov_k, ov_v, is_split, is_store, can_split, lo_v, hi_v, pop;
   logic slot_free, store_we, store_full, add_done;
   addr_type b_lo, b_hi;
   logic [DEPTH_BITS-1:0] d_next;
   logic [STACK_IDX_BITS-1:0] pop_idx;

   // scan path
   addr_type len_ff, low_ff;
   logic big_ff;
   logic [SLOT_CNT_BITS-1:0] issue_idx_ff, issue_idx_in;
   logic v1_ff, v1_in, v2_ff, v2_in;
   addr_type rd_s_ff, rd_e_ff, first2_ff, en2_ff, room;
   logic [SLOT_IDX_BITS-1:0] idx1_ff, idx2_ff;
   logic ok2_ff;
   logic [ADDR_BITS:0] align_sum;
   logic issue_more, issue_go, hit_now, drained;

   // memory write port
   logic mem_we, mem_we_end;
   logic [SLOT_IDX_BITS-1:0] mem_addr;
   addr_type mem_start_data;

   // result
   status_type res_status_ff, out_status_ff;
   addr_type res_addr_ff, out_addr_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_start_ff <= KERNEL_START_RST;
         kernel_end_ff   <= KERNEL_END_RST;
         vga_base_ff     <= VGA_BASE_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KERNEL_START: kernel_start_ff <= csr_data;
            CSR_KERNEL_END:   kernel_end_ff   <= csr_data;
            CSR_VGA_BASE:     vga_base_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // display window end saturates at the top of the address range
   assign vga_sum    = {1'b0, vga_base_ff} + (ADDR_BITS+1)'(PAGE_BYTES);
   assign vga_end_in = vga_sum[ADDR_BITS] ? ADDR_MASK : vga_sum[ADDR_BITS-1:0];

   always_ff @(posedge clock) begin
      vga_end_ff <= vga_end_in;
   end

   // page normalisation
   assign s_hi      = piece_s_ff[ADDR_BITS-1:PAGE_BITS];
   assign s_frac_nz = |piece_s_ff[PAGE_BITS-1:0];
   assign s_over    = (&s_hi) & s_frac_nz;
   assign s_hi_up   = s_hi + HI_BITS'(s_frac_nz);
   assign s_up      = {s_hi_up, {PAGE_BITS{1'b0}}};
   assign s_norm    = (s_up == '0) ? PAGE_ADDR : s_up;
   assign e_norm    = {piece_e_ff[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (cmd.norm) begin
         ns_ff     <= s_norm;
         ne_ff     <= e_norm;
         nempty_ff <= s_over || (s_norm >= e_norm);
      end
   end

   // classification against kernel range and display page
   always_comb begin
      in_k      = (ns_ff >= kernel_start_ff) && (ne_ff < kernel_end_ff);
      ov_k      = (ns_ff < kernel_end_ff && ne_ff >= kernel_end_ff) ||
                  (ns_ff <= kernel_start_ff && ne_ff > kernel_start_ff);
      ov_v      = (ns_ff < vga_end_ff && ne_ff >= vga_end_ff) ||
                  (ns_ff <= vga_base_ff && ne_ff > vga_base_ff);
      b_lo      = ov_k ? kernel_start_ff : vga_base_ff;
      b_hi      = ov_k ? kernel_end_ff : vga_end_ff;
      is_split  = !nempty_ff && !in_k && (ov_k || ov_v);
      is_store  = !nempty_ff && !in_k && !ov_k && !ov_v;
      can_split = piece_d_ff < DEPTH_BITS'(SPLIT_LIMIT);
      lo_v      = cmd.classify && is_split && can_split && (ns_ff < b_lo);
      hi_v      = cmd.classify && is_split && can_split && (ne_ff > b_hi);
      slot_free = next_slot_ff < SLOT_CNT_BITS'(REGION_SLOTS);
      store_we  = cmd.classify && is_store && slot_free;
      store_full = cmd.classify && is_store && !slot_free && (piece_d_ff == '0);
      pop       = !lo_v && !hi_v && (sp_ff != '0);
      d_next    = piece_d_ff + DEPTH_BITS'(1);
      pop_idx   = STACK_IDX_BITS'(sp_ff - STACK_CNT_BITS'(1));
      add_done  = !lo_v && !hi_v && (sp_ff == '0);
   end

   always_comb begin
      sp_in   = sp_ff;
      full_in = full_ff;
      if (cmd.load) begin
         sp_in   = '0;
         full_in = 1'b0;
      end else if (cmd.classify) begin
         if (lo_v && hi_v) begin
            sp_in = sp_ff + STACK_CNT_BITS'(1);
         end else if (pop) begin
            sp_in = sp_ff - STACK_CNT_BITS'(1);
         end
         if (store_full) begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff   <= '0;
         full_ff <= 1'b0;
      end else begin
         sp_ff   <= sp_in;
         full_ff <= full_in;
      end
   end

   // current piece and pending upper pieces
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         piece_s_ff <= req_range_start;
         piece_e_ff <= req_range_end;
         piece_d_ff <= '0;
      end else if (cmd.classify) begin
         if (lo_v) begin
            piece_s_ff <= ns_ff;
            piece_e_ff <= b_lo;
            piece_d_ff <= d_next;
            if (hi_v) begin
               stk_s_ff[sp_ff[STACK_IDX_BITS-1:0]] <= b_hi;
               stk_e_ff[sp_ff[STACK_IDX_BITS-1:0]] <= ne_ff;
               stk_d_ff[sp_ff[STACK_IDX_BITS-1:0]] <= d_next;
            end
         end else if (hi_v) begin
            piece_s_ff <= b_hi;
            piece_e_ff <= ne_ff;
            piece_d_ff <= d_next;
         end else if (pop) begin
            piece_s_ff <= stk_s_ff[pop_idx];
            piece_e_ff <= stk_e_ff[pop_idx];
            piece_d_ff <= stk_d_ff[pop_idx];
         end
      end
   end

   // first-fit scan: read, align, compare
   assign issue_more = issue_idx_ff < next_slot_ff;
   assign issue_go   = cmd.scan && !hit_now && issue_more;
   assign align_sum  = {1'b0, rd_s_ff} + {1'b0, low_ff};
   assign room       = en2_ff - first2_ff;
   assign hit_now    = cmd.scan && v2_ff && ok2_ff && (first2_ff < en2_ff) &&
                       (room >= len_ff);
   assign drained    = !v1_ff && !v2_ff && !issue_more;
   assign stat       = '{add_done: add_done, scan_done: hit_now || drained};

   always_comb begin
      issue_idx_in = issue_idx_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      if (cmd.load) begin
         issue_idx_in = '0;
         v1_in        = 1'b0;
         v2_in        = 1'b0;
      end else if (cmd.scan) begin
         if (issue_go) begin
            issue_idx_in = issue_idx_ff + SLOT_CNT_BITS'(1);
         end
         v1_in = issue_go;
         v2_in = v1_ff && !hit_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_idx_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         issue_idx_ff <= issue_idx_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff <= req_length;
         low_ff <= ~(ADDR_MASK << req_align_log2);
         big_ff <= req_align_log2 >= ALIGN_BITS'(ADDR_BITS);
      end
      if (cmd.scan) begin
         first2_ff <= align_sum[ADDR_BITS-1:0] & ~low_ff;
         en2_ff    <= rd_e_ff & ~low_ff;
         ok2_ff    <= !align_sum[ADDR_BITS] && !big_ff;
         idx2_ff   <= idx1_ff;
      end
   end

   // table memory, one write port and one registered read port
   always_comb begin
      mem_we         = store_we || hit_now;
      mem_we_end     = store_we;
      mem_addr       = store_we ? next_slot_ff[SLOT_IDX_BITS-1:0] : idx2_ff;
      mem_start_data = store_we ? ns_ff : (first2_ff + len_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_start_mem[mem_addr] <= mem_start_data;
      end
      if (mem_we_end) begin
         slot_end_mem[mem_addr] <= ne_ff;
      end
      if (issue_go) begin
         rd_s_ff <= slot_start_mem[issue_idx_ff[SLOT_IDX_BITS-1:0]];
         rd_e_ff <= slot_end_mem[issue_idx_ff[SLOT_IDX_BITS-1:0]];
         idx1_ff <= issue_idx_ff[SLOT_IDX_BITS-1:0];
      end
   end

   // slots fill in order and are never freed, so the count marks the valid ones
   assign next_slot_in = store_we ? next_slot_ff + SLOT_CNT_BITS'(1) : next_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff <= '0;
      end else begin
         next_slot_ff <= next_slot_in;
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (cmd.classify && add_done) begin
         res_status_ff <= (full_ff || store_full) ? STATUS_FULL : STATUS_OK;
         res_addr_ff   <= '0;
      end else if (cmd.scan && hit_now) begin
         res_status_ff <= STATUS_OK;
         res_addr_ff   <= first2_ff;
      end else if (cmd.scan && drained) begin
         res_status_ff <= STATUS_OOM;
         res_addr_ff   <= '0;
      end
      if (cmd.resp_load) begin
         out_status_ff <= res_status_ff;
         out_addr_ff   <= res_addr_ff;
      end
   end

   assign rsp_status  = out_status_ff;
   assign rsp_address = out_addr_ff;

endmodule
`default_nettype wire

// ----- src/bral_ctrl.sv -----
// controller state machine sequencing add and alloc requests
`default_nettype none
module bral_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_mode,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire bral_pkg::bral_stat_type stat,
   output bral_pkg::bral_cmd_type       cmd
);
   import bral_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_NORM  = 5'b00010,
      ST_CLASS = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (mode_type'(req_mode) == MODE_ALLOC) ? ST_SCAN : ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = stat.add_done ? ST_RESP : ST_NORM;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // output register must be free before the result moves in
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.resp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
